// ===== design/ifs_chaos_game_point_generator_defines.svh =====
// Assertion macros shared by the checker
`ifndef IFS_CHAOS_GAME_POINT_GENERATOR_DEFINES_SVH
`define IFS_CHAOS_GAME_POINT_GENERATOR_DEFINES_SVH
// Implication checked at every clock edge outside reset
`define IFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define IFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/ifs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared constants, codes and types of the chaos game point generator.
// ----------------------------------------------------------------------------
package ifs_pkg;
    localparam int MAPS_DEF       = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int NCOEF          = 6;
    localparam int MAX_MAPS       = 4;
    localparam int DATA_W         = 32;
    localparam int DRAW_W         = 7;
    localparam int CNT_OUT_W      = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ITERATE = 2'd2;
    localparam logic [1:0] CMD_ADVANCE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THR0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DRAWN = 3'd4;

    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]              command;
        logic [1:0]              map_index;
        logic [2:0]              coeff_index;
        logic signed [DATA_W-1:0] load_value;
        logic signed [DATA_W-1:0] load_lower;
        logic signed [DATA_W-1:0] load_upper;
        logic signed [DATA_W-1:0] load_step;
        logic [DRAW_W-1:0]       random_draw;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic                     drawn;
        logic [1:0]               map_used;
        logic [CNT_OUT_W-1:0]     point_count;
        logic signed [DATA_W-1:0] box_x_min;
        logic signed [DATA_W-1:0] box_x_max;
        logic signed [DATA_W-1:0] box_y_min;
        logic signed [DATA_W-1:0] box_y_max;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
    } t_cfg_item;

    // Saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'(S_MAX)) begin
            r = S_MAX;
        end else if (v < 34'(S_MIN)) begin
            r = S_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction
endpackage

// ===== design/ifs_chan_if.sv =====
// ----------------------------------------------------------------------------
// ifs_in_if / ifs_out_if / ifs_cfg_if
// Valid-ready channels that carry input, result and configuration items.
// ----------------------------------------------------------------------------
interface ifs_in_if import ifs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ifs_out_if import ifs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ifs_cfg_if import ifs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ifs_coeff_mem.sv =====
// ----------------------------------------------------------------------------
// ifs_coeff_mem
// Coefficient store: value, lower, upper and step per entry, one read and
// one write port, registered read data, valid bits for the zero reset.
// ----------------------------------------------------------------------------
module ifs_coeff_mem import ifs_pkg::*; #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [4*DATA_W-1:0]   o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [4*DATA_W-1:0]   i_wr_data
);
    logic [4*DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    logic [4*DATA_W-1:0] r_rd;
    logic                r_rd_vld;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[i_rd_addr];
        r_rd_vld <= r_vld[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;
endmodule

// ===== design/ifs_chaos_game_point_generator.sv =====
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_generator
// Chaos game point generator for an iterated function system.
// ----------------------------------------------------------------------------
// Load and start: the item passes through the read state to the output state.
// Iterate: six coefficients are read through the registered store, then two
// multiply and add passes follow, then the result is registered. Advance: one
// entry read per cycle, written back advanced in the cycle after its read.
// One item at a time; the next item is taken after the result leaves.
// Reset clears the store through valid bits at once; no clearing pass.
module ifs_chaos_game_point_generator import ifs_pkg::*; #(
    parameter int MAPS       = MAPS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ifs_in_if.sink      in_ch,
    ifs_out_if.source   out_ch,
    ifs_cfg_if.sink     cfg_ch
);
    localparam int DEPTH = MAPS * NCOEF;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * DATA_W;
    localparam int SW    = PW - FRAC_BITS + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_ADV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]               r_st;
    t_in_item                 r_in;
    logic [DRAW_W-1:0]        r_thr [MAX_MAPS];
    logic [CNT_OUT_W-1:0]     r_first;
    logic signed [DATA_W-1:0] r_x, r_y, r_minx, r_maxx, r_miny, r_maxy;
    logic [COUNT_BITS-1:0]    r_cnt;
    logic [1:0]               r_map;
    logic [1:0]               r_sel;
    logic [AW-1:0]            r_base;
    logic [AW:0]              r_k;
    logic                     r_rd_pend;
    logic signed [DATA_W-1:0] r_c [NCOEF];
    logic signed [PW-1:0]     r_p0, r_p1;
    logic                     r_half;
    logic signed [DATA_W-1:0] r_nx;
    t_out_item                r_out;
    logic                     r_ovld;
    logic                     r_drawn;

    logic [AW-1:0]            rd_addr, wr_addr;
    logic [4*DATA_W-1:0]      rd_data, wr_data;
    logic                     wr_en;
    logic [1:0]               sel;
    logic [AW-1:0]            rd_cur;
    logic signed [DATA_W-1:0] m_val, m_low, m_up, m_stp, adv_v, adv_s;
    logic signed [SW-1:0]     sum3;
    logic signed [DATA_W-1:0] aff;
    logic [COUNT_BITS-1:0]    cnt_nx;

    assign in_ch.ready  = (r_st == ST_IDLE) && !r_ovld;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovld;
    assign out_ch.data  = r_out;

    // Map choice: first map whose threshold exceeds the draw, else the last map
    always_comb begin
        sel = 2'(MAPS - 1);
        for (int m = MAPS - 1; m >= 0; m--) begin
            if (in_ch.data.random_draw < r_thr[m]) begin
                sel = 2'(m);
            end
        end
    end

    assign rd_cur  = AW'(r_k);
    assign rd_addr = (r_st == ST_ADV) ? rd_cur : AW'(r_base + rd_cur);
    assign {m_val, m_low, m_up, m_stp} = rd_data;
    assign adv_v   = sat34((DATA_W+2)'(m_val) + (DATA_W+2)'(m_stp));
    assign adv_s   = (adv_v > m_up || adv_v < m_low)
                   ? ((m_stp == S_MIN) ? S_MAX : -m_stp) : m_stp;
    // Floor-shifted products plus the constant, full width before saturation
    assign sum3    = SW'(r_p0 >>> FRAC_BITS) + SW'(r_p1 >>> FRAC_BITS)
                   + SW'(r_half ? r_c[5] : r_c[2]);
    assign aff     = (sum3 > SW'(S_MAX)) ? S_MAX
                   : (sum3 < SW'(S_MIN)) ? S_MIN : sum3[DATA_W-1:0];
    assign cnt_nx  = (&r_cnt) ? r_cnt : r_cnt + 1'b1;

    // Store write: load, or write back an advanced entry
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(r_k - 1'b1);
        wr_data = {adv_v, m_low, m_up, adv_s};
        if (r_st == ST_RD && r_in.command == CMD_LOAD) begin
            wr_en   = (r_in.coeff_index < 3'(NCOEF)) && (32'(r_in.map_index) < MAPS);
            wr_addr = AW'(32'(r_in.map_index) * NCOEF + 32'(r_in.coeff_index));
            wr_data = {r_in.load_value, r_in.load_lower, r_in.load_upper, r_in.load_step};
        end else if (r_st == ST_ADV && r_rd_pend) begin
            wr_en = 1'b1;
        end
    end

    ifs_coeff_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk, .i_rst_n, .i_rd_addr(rd_addr), .o_rd_data(rd_data),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MAX_MAPS; m++) r_thr[m] <= 7'd100;
            r_first <= 16'd1;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.data.index <= REG_THR3) begin
                r_thr[cfg_ch.data.index[1:0]] <= cfg_ch.data.data[DRAW_W-1:0];
            end else if (cfg_ch.data.index == REG_FIRST_DRAWN) begin
                r_first <= cfg_ch.data.data[CNT_OUT_W-1:0];
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ovld <= 1'b0; r_x <= '0; r_y <= '0; r_cnt <= '0;
            r_map <= '0; r_minx <= S_MAX; r_miny <= S_MAX; r_maxx <= S_MIN;
            r_maxy <= S_MIN; r_k <= '0; r_rd_pend <= 1'b0; r_half <= 1'b0;
            r_base <= '0; r_drawn <= 1'b0; r_sel <= '0;
        end else begin
            if (r_ovld && out_ch.ready) r_ovld <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in <= in_ch.data; r_k <= '0; r_rd_pend <= 1'b0;
                        r_drawn <= 1'b0;
                        r_sel  <= sel;
                        r_base <= AW'(32'(sel) * NCOEF);
                        r_st <= (in_ch.data.command == CMD_ADVANCE) ? ST_ADV : ST_RD;
                    end
                end
                ST_RD: begin
                    if (r_in.command == CMD_START) begin
                        r_x <= '0; r_y <= '0; r_cnt <= '0;
                        r_minx <= S_MAX; r_miny <= S_MAX; r_maxx <= S_MIN; r_maxy <= S_MIN;
                        r_st <= ST_OUT;
                    end else if (r_in.command == CMD_LOAD) begin
                        r_st <= ST_OUT;
                    end else begin
                        // Fetch six coefficients of the chosen map
                        if (r_rd_pend) r_c[3'(r_k - 1'b1)] <= m_val;
                        r_rd_pend <= (r_k < (AW+1)'(NCOEF));
                        r_k <= r_k + 1'b1;
                        if (r_k == (AW+1)'(NCOEF)) begin
                            r_half <= 1'b0; r_st <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_p0 <= PW'(r_half ? r_c[3] : r_c[0]) * PW'(r_x);
                    r_p1 <= PW'(r_half ? r_c[4] : r_c[1]) * PW'(r_y);
                    r_st <= ST_ADD;
                end
                ST_ADD: begin
                    if (!r_half) begin
                        r_nx <= aff; r_half <= 1'b1; r_st <= ST_MUL;
                    end else begin
                        r_x <= r_nx; r_y <= aff;
                        r_map <= r_sel;
                        r_cnt <= cnt_nx;
                        if (32'(cnt_nx) >= 32'(r_first)) begin
                            r_drawn <= 1'b1;
                            if (r_nx < r_minx) r_minx <= r_nx;
                            if (r_nx > r_maxx) r_maxx <= r_nx;
                            if (aff < r_miny) r_miny <= aff;
                            if (aff > r_maxy) r_maxy <= aff;
                        end
                        r_st <= ST_OUT;
                    end
                end
                ST_ADV: begin
                    // Read one entry, write it back advanced next cycle
                    r_rd_pend <= (r_k < (AW+1)'(DEPTH));
                    r_k <= r_k + 1'b1;
                    if (r_k == (AW+1)'(DEPTH)) r_st <= ST_OUT;
                end
                ST_OUT: begin
                    r_out.point_x     <= r_x;
                    r_out.point_y     <= r_y;
                    r_out.drawn       <= r_drawn;
                    r_out.map_used    <= r_map;
                    r_out.point_count <= CNT_OUT_W'(r_cnt);
                    r_out.box_x_min   <= r_minx;
                    r_out.box_x_max   <= r_maxx;
                    r_out.box_y_min   <= r_miny;
                    r_out.box_y_max   <= r_maxy;
                    r_ovld <= 1'b1;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== design/ifs_checker.sv =====
// ----------------------------------------------------------------------------
// ifs_checker
// Port-level checks of the point generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "ifs_chaos_game_point_generator_defines.svh"
module ifs_checker import ifs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_data
);
    // A waiting result holds its payload
    `IFS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
    // No new item while a result waits
    `IFS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready, "input taken while result pending")
    // A drawn point has a nonzero count
    `IFS_ASSERT_IMP(a_drawn_cnt, i_clk, i_rst_n, out_valid && out_data.drawn, out_data.point_count != 16'd0, "drawn point with zero count")
    // Hold off the input the cycle after an accept
    `IFS_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "ready right after accept")
endmodule

bind ifs_chaos_game_point_generator ifs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load, start, iterate and advance commands plus register writes into
// the chaos game point generator, predicts every result in a local model of
// the map store, point and bounding box, and compares each result field by
// field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ifs_pkg::*;

    localparam int NMAPS    = 4;
    localparam int CNT_BITS = 16;
    localparam int FRAC     = 24;
    localparam int DEPTH    = NMAPS * NCOEF;
    localparam int LIMIT    = 2000000;

    logic i_clk;
    logic i_rst_n;

    ifs_in_if  in_ch ();
    ifs_out_if out_ch ();
    ifs_cfg_if cfg_ch ();

    ifs_chaos_game_point_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    // Predictor state
    logic signed [31:0] m_val [DEPTH];
    logic signed [31:0] m_step[DEPTH];
    logic signed [31:0] m_lo  [DEPTH];
    logic signed [31:0] m_hi  [DEPTH];
    logic signed [31:0] m_x, m_y, m_xmin, m_xmax, m_ymin, m_ymax;
    logic [31:0]        m_count;
    logic [1:0]         m_last;
    logic [6:0]         m_thr[4];
    logic [15:0]        m_first;

    t_in_item  cmd_q[$];
    t_out_item expected_q[$];
    int        errors;
    int        cycles;
    bit        stim_done;

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF) return S_MAX;
        if (v < -66'sh8000_0000) return S_MIN;
        return v[31:0];
    endfunction

    // Floor shift via arithmetic shift of the signed product
    function automatic logic signed [31:0] map_coord(input logic signed [31:0] a,
            input logic signed [31:0] b, input logic signed [31:0] c,
            input logic signed [31:0] x, input logic signed [31:0] y);
        logic signed [63:0] p0, p1;
        logic signed [65:0] s;
        p0 = (64'(a) * 64'(x)) >>> FRAC;
        p1 = (64'(b) * 64'(y)) >>> FRAC;
        s  = 66'(p0) + 66'(p1) + 66'(c);
        return clip32(s);
    endfunction

    function automatic void clear_box();
        m_xmin = S_MAX; m_ymin = S_MAX;
        m_xmax = S_MIN; m_ymax = S_MIN;
    endfunction

    function automatic t_out_item predict_point(input t_in_item it);
        t_out_item r;
        int n, k;
        logic signed [31:0] nx, ny, v;
        logic drawn;
        drawn = 1'b0;
        case (it.command)
            CMD_LOAD: begin
                if (it.coeff_index < NCOEF && it.map_index < NMAPS) begin
                    k = it.map_index * NCOEF + it.coeff_index;
                    m_val[k] = it.load_value; m_lo[k] = it.load_lower;
                    m_hi[k] = it.load_upper; m_step[k] = it.load_step;
                end
            end
            CMD_START: begin
                m_x = 0; m_y = 0; m_count = 0;
                clear_box();
            end
            CMD_ITERATE: begin
                n = NMAPS - 1;
                for (int m = NMAPS - 1; m >= 0; m--)
                    if (it.random_draw < m_thr[m]) n = m;
                k = n * NCOEF;
                nx = map_coord(m_val[k], m_val[k+1], m_val[k+2], m_x, m_y);
                ny = map_coord(m_val[k+3], m_val[k+4], m_val[k+5], m_x, m_y);
                m_x = nx; m_y = ny; m_last = n[1:0];
                if (m_count < (32'd1 << CNT_BITS) - 1) m_count++;
                if (m_count >= m_first) begin
                    drawn = 1'b1;
                    if (nx < m_xmin) m_xmin = nx;
                    if (nx > m_xmax) m_xmax = nx;
                    if (ny < m_ymin) m_ymin = ny;
                    if (ny > m_ymax) m_ymax = ny;
                end
            end
            default: begin
                for (int j = 0; j < DEPTH; j++) begin
                    v = clip32(66'(m_val[j]) + 66'(m_step[j]));
                    m_val[j] = v;
                    if (v > m_hi[j] || v < m_lo[j]) m_step[j] = clip32(-66'(m_step[j]));
                end
            end
        endcase
        r.point_x = m_x; r.point_y = m_y; r.drawn = drawn; r.map_used = m_last;
        r.point_count = m_count[15:0];
        r.box_x_min = m_xmin; r.box_x_max = m_xmax;
        r.box_y_min = m_ymin; r.box_y_max = m_ymax;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic t_in_item mk_load(input int mi, input int ci, input logic [31:0] v,
            input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] st);
        t_in_item it;
        it = '0;
        it.command = CMD_LOAD; it.map_index = mi[1:0]; it.coeff_index = ci[2:0];
        it.load_value = v; it.load_lower = lo; it.load_upper = hi; it.load_step = st;
        it.random_draw = 7'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_cmd(input logic [1:0] c, input logic [6:0] d);
        t_in_item it;
        it = '0;
        it.command = c; it.random_draw = d;
        it.map_index = 2'($urandom); it.coeff_index = 3'($urandom);
        it.load_value = $urandom; it.load_lower = $urandom;
        it.load_upper = $urandom; it.load_step = $urandom;
        return it;
    endfunction

    // Input driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_gap > 0 || cmd_q.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (in_gap > 0) in_gap--;
            end else begin
                t_in_item it;
                it = cmd_q.pop_front();
                expected_q.push_back(predict_point(it));
                in_ch.data  <= it;
                in_ch.valid <= 1'b1;
                in_gap = gap_len();
            end
        end
    end

    // Result monitor with random stalls
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_out_item got, exp_r;
                got = out_ch.data;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.point_x !== exp_r.point_x)
                        $display("%0t: point_x exp %h got %h", $time, exp_r.point_x, got.point_x);
                    if (got.point_y !== exp_r.point_y)
                        $display("%0t: point_y exp %h got %h", $time, exp_r.point_y, got.point_y);
                    if (got.drawn !== exp_r.drawn)
                        $display("%0t: drawn exp %h got %h", $time, exp_r.drawn, got.drawn);
                    if (got.map_used !== exp_r.map_used)
                        $display("%0t: map_used exp %h got %h", $time, exp_r.map_used,
                                 got.map_used);
                    if (got.point_count !== exp_r.point_count)
                        $display("%0t: point_count exp %h got %h", $time,
                                 exp_r.point_count, got.point_count);
                    if (got.box_x_min !== exp_r.box_x_min)
                        $display("%0t: box_x_min exp %h got %h", $time, exp_r.box_x_min,
                                 got.box_x_min);
                    if (got.box_x_max !== exp_r.box_x_max)
                        $display("%0t: box_x_max exp %h got %h", $time, exp_r.box_x_max,
                                 got.box_x_max);
                    if (got.box_y_min !== exp_r.box_y_min)
                        $display("%0t: box_y_min exp %h got %h", $time, exp_r.box_y_min,
                                 got.box_y_min);
                    if (got.box_y_max !== exp_r.box_y_max)
                        $display("%0t: box_y_max exp %h got %h", $time, exp_r.box_y_max,
                                 got.box_y_max);
                    if (got !== exp_r) errors++;
                end
            end
            if (out_gap > 0) begin
                out_ch.ready <= 1'b0;
                out_gap--;
            end else begin
                out_ch.ready <= 1'b1;
                out_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_ch.data  <= '{index: idx, data: val};
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx <= REG_THR3) m_thr[idx] = val[6:0];
        else if (idx == REG_FIRST_DRAWN) m_first = val[15:0];
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || expected_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Frame: load all maps, mostly contracting, start, then mostly iterate
    task automatic queue_frame(input int iters);
        for (int m = 0; m < NMAPS; m++)
            for (int c = 0; c < NCOEF; c++)
                if ($urandom_range(0, 3) == 0)
                    cmd_q.push_back(mk_load(m, c, rand_word(), rand_word(), rand_word(),
                                            rand_word()));
                else
                    cmd_q.push_back(mk_load(m, c,
                        32'($signed($urandom_range(0, 32'h0180_0000)) - 32'sh00C0_0000),
                        32'hFF00_0000, 32'h0100_0000,
                        32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000)));
        cmd_q.push_back(mk_cmd(CMD_START, 0));
        for (int i = 0; i < iters; i++) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 80) cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'($urandom_range(0, 99))));
            else if (p < 88) cmd_q.push_back(mk_cmd(CMD_ADVANCE, 7'($urandom)));
            else if (p < 93) cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'($urandom)));
            else if (p < 97) cmd_q.push_back(mk_load(3'($urandom), 3'($urandom),
                                  rand_word(), rand_word(), rand_word(), rand_word()));
            else cmd_q.push_back(mk_cmd(CMD_START, 7'($urandom)));
        end
    endtask

    // Stimulus
    initial begin
        int sent;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        errors = 0; cycles = 0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            m_val[k] = 0; m_step[k] = 0; m_lo[k] = 0; m_hi[k] = 0;
        end
        m_x = 0; m_y = 0; m_count = 0; m_last = 0;
        clear_box();
        for (int t = 0; t < 4; t++) m_thr[t] = 7'd100;
        m_first = 16'd1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, saturation, out-of-range loads, empty box
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd0));
        cmd_q.push_back(mk_load(0, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF));
        cmd_q.push_back(mk_load(0, 0, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000));
        cmd_q.push_back(mk_load(0, 3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000));
        cmd_q.push_back(mk_load(0, 6, 32'h1234_5678, 32'h0, 32'h0, 32'h1));
        cmd_q.push_back(mk_load(3, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF));
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd99));
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd127));
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd0));
        cmd_q.push_back(mk_cmd(CMD_ADVANCE, 7'd0));
        cmd_q.push_back(mk_cmd(CMD_ADVANCE, 7'd0));
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd50));
        cmd_q.push_back(mk_cmd(CMD_START, 7'd0));
        cmd_q.push_back(mk_load(1, 1, 32'hFF80_0000, 32'hFF00_0000, 32'h0100_0000,
                                32'h0010_0000));
        cmd_q.push_back(mk_cmd(CMD_ITERATE, 7'd1));
        cmd_q.push_back(mk_cmd(CMD_ADVANCE, 7'd1));
        sent = 16;
        drain();

        // Threshold extremes and first_drawn settings, each with a frame
        write_reg(REG_THR0, 32'd0);
        write_reg(REG_THR0 + 3'd1, 32'd100);
        write_reg(REG_THR0 + 3'd2, 32'd0);
        write_reg(REG_THR3, 32'd127);
        write_reg(REG_FIRST_DRAWN, 32'd0);
        queue_frame(40); sent += 65;
        drain();
        write_reg(REG_THR0, 32'd0);
        write_reg(REG_THR0 + 3'd1, 32'd0);
        write_reg(REG_THR0 + 3'd2, 32'd0);
        write_reg(REG_THR3, 32'd0);
        write_reg(REG_FIRST_DRAWN, 32'hFFFF);
        queue_frame(40); sent += 65;
        drain();
        while (sent < 1100) begin
            int a, b, c;
            a = $urandom_range(0, 100); b = $urandom_range(a, 100);
            c = $urandom_range(b, 100);
            write_reg(REG_THR0, a);
            write_reg(REG_THR0 + 3'd1, b);
            write_reg(REG_THR0 + 3'd2, c);
            write_reg(REG_THR3, $urandom_range(0, 127));
            write_reg(REG_FIRST_DRAWN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30));
            queue_frame(150); sent += 175;
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
